// ===== rtl/hls_pkg.sv =====
// Shared types and constants for the horizontal linear scaler.
// Used by hls_mix and horizontal_linear_scaler_top; no dependencies.
package hls_pkg;

    typedef enum logic
    {
        FMT_ARGB   = 1'b0,
        FMT_RGB565 = 1'b1
    } hls_fmt_t;

    // configuration register indexes
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_STEP   = 2'd1;
    localparam logic [1:0] CFG_COUNT  = 2'd2;

    localparam int unsigned PIX_W   = 32;
    localparam int unsigned STEP_W  = 13;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned POS_W   = 25;
    localparam int unsigned IDX_W   = 17;

    // outputs emitted per source pixel at most
    localparam logic [6:0] STEP_LIMIT = 7'd64;

    localparam logic [23:0] LANE_PAIR_MASK = 24'hff00ff;
    localparam logic [31:0] LANES_BR       = 32'h00ff00ff;
    localparam logic [31:0] LANES_AG       = 32'hff00ff00;
    localparam logic [15:0] FIELDS_RB      = 16'hf81f;
    localparam logic [15:0] FIELD_G        = 16'h07e0;

    // one pass of the shared weighting unit
    typedef struct packed
    {
        hls_fmt_t   fmt;
        logic       phase_hi;
        logic [7:0] frac;
    } hls_mix_ctl_t;

endpackage

// ===== rtl/hls_mix.sv =====
// Shared weighting unit: w1*c1 + w2*c2 over one packed lane pair or field group.
// Depends on hls_pkg. Two passes (low, high) build one output pixel.
module hls_mix
(
    input  hls_pkg::hls_mix_ctl_t ctl,
    input  logic [31:0]           a,
    input  logic [31:0]           b,
    output logic [31:0]           part
);
    import hls_pkg::*;

    logic [8:0]  wb;
    logic [8:0]  wa;
    logic [23:0] x;
    logic [23:0] y;
    logic [32:0] prod_a;
    logic [32:0] prod_b;
    logic [33:0] sum;

    always_comb
    begin
        wb = 9'd0;
        wa = 9'd0;
        x = 24'd0;
        y = 24'd0;
        case (ctl.fmt)
            FMT_ARGB:
            begin
                wb = {1'b0, ctl.frac};
                wa = 9'd256 - wb;
                if (ctl.phase_hi)
                begin
                    x = a[31:8] & LANE_PAIR_MASK;
                    y = b[31:8] & LANE_PAIR_MASK;
                end
                else
                begin
                    x = a[23:0] & LANE_PAIR_MASK;
                    y = b[23:0] & LANE_PAIR_MASK;
                end
            end
            FMT_RGB565:
            begin
                wb = {3'b000, ctl.frac[7:2]};
                wa = 9'd64 - wb;
                if (ctl.phase_hi)
                begin
                    x = {8'd0, a[15:0] & FIELDS_RB};
                    y = {8'd0, b[15:0] & FIELDS_RB};
                end
                else
                begin
                    x = {8'd0, a[15:0] & FIELD_G};
                    y = {8'd0, b[15:0] & FIELD_G};
                end
            end
            default:
            begin
                wb = 9'd0;
                wa = 9'd0;
            end
        endcase
    end

    assign prod_a = 33'(wa) * 33'(x);
    assign prod_b = 33'(wb) * 33'(y);
    assign sum    = {1'b0, prod_a} + {1'b0, prod_b};

    always_comb
    begin
        part = 32'd0;
        case (ctl.fmt)
            FMT_ARGB:
            begin
                if (ctl.phase_hi)
                    part = sum[31:0] & LANES_AG;
                else
                    part = 32'(sum >> 8) & LANES_BR;
            end
            FMT_RGB565:
            begin
                if (ctl.phase_hi)
                    part = {16'd0, sum[21:6] & FIELDS_RB};
                else
                    part = {16'd0, sum[21:6] & FIELD_G};
            end
            default:
                part = 32'd0;
        endcase
    end

endmodule

// ===== rtl/horizontal_linear_scaler_top.sv =====
// Channel | Signals                                   | Direction of flow
// src     | src_valid, src_stall, src_pixel, line_start | into block
// res     | res_valid, res_stall, out_pixel, line_last  | out of block
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data   | into block
//
// A line-start pixel, or a pixel while no line is active, is taken without leaving ST_IDLE.
// Other pixels loop ST_CHECK, ST_MIX_LO, ST_MIX_HI per output due (at most 64 per
// pixel), ending in ST_CHECK: each output is two passes of the shared weighting unit.
// res_stall only holds the final pass of the next output; src_stall is high while busy.
// Reset clears the line state and loads register defaults; no clearing pass.
//
// Top level of the horizontal linear scaler: sequencer, line state, output register.
// Depends on hls_pkg and hls_mix.
module horizontal_linear_scaler_top
#(
    parameter int MAX_OUTPUTS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [31:0] src_pixel,
    input  logic        line_start,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] out_pixel,
    output logic        line_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import hls_pkg::*;

    typedef enum logic [3:0]
    {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_MIX_LO = 4'b0100,
        ST_MIX_HI = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    hls_fmt_t             fmt_reg, fmt_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [COUNT_W-1:0]   remain_reg, remain_next;
    logic                 active_reg, active_next;
    logic [6:0]           burst_reg, burst_next;
    logic                 res_valid_reg, res_valid_next;
    logic [PIX_W-1:0]     prev_reg, prev_next;
    logic [PIX_W-1:0]     cur_reg, cur_next;
    logic [PIX_W-1:0]     lo_part_reg, lo_part_next;
    logic [PIX_W-1:0]     out_pixel_reg, out_pixel_next;
    logic                 line_last_reg, line_last_next;

    hls_mix_ctl_t         mix_ctl;
    logic [PIX_W-1:0]     mix_part;
    logic                 src_take;
    logic                 res_take;
    logic                 out_free;
    logic [COUNT_W-1:0]   start_count;

    assign src_stall = (state_reg != ST_IDLE);
    assign src_take  = src_valid && !src_stall;
    assign res_take  = res_valid_reg && !res_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign cfg_ready = 1'b1;

    assign mix_ctl.fmt      = fmt_reg;
    assign mix_ctl.phase_hi = (state_reg == ST_MIX_HI);
    assign mix_ctl.frac     = pos_reg[7:0];

    hls_mix u_mix
    (
        .ctl  (mix_ctl),
        .a    (prev_reg),
        .b    (cur_reg),
        .part (mix_part)
    );

    always_comb
    begin
        if (int'(count_reg) > MAX_OUTPUTS)
            start_count = COUNT_W'(MAX_OUTPUTS);
        else
            start_count = count_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        fmt_next       = fmt_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        remain_next    = remain_reg;
        active_next    = active_reg;
        burst_next     = burst_reg;
        res_valid_next = res_valid_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        lo_part_next   = lo_part_reg;
        out_pixel_next = out_pixel_reg;
        line_last_next = line_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FORMAT: fmt_next   = hls_fmt_t'(cfg_data[0]);
                CFG_STEP:   step_next  = cfg_data;
                CFG_COUNT:  count_next = cfg_data;
                default:    ;
            endcase
        end

        if (res_take)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (src_take)
                begin
                    if (line_start)
                    begin
                        prev_next   = src_pixel;
                        idx_next    = '0;
                        pos_next    = '0;
                        remain_next = start_count;
                        active_next = (start_count != '0);
                    end
                    else if (active_reg)
                    begin
                        cur_next   = src_pixel;
                        burst_next = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if ((burst_reg < STEP_LIMIT) && (remain_reg != '0) &&
                    (pos_reg[POS_W-1:8] <= idx_reg))
                begin
                    state_next = ST_MIX_LO;
                end
                else
                begin
                    if (remain_reg == '0)
                        active_next = 1'b0;
                    prev_next  = cur_reg;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MIX_LO:
            begin
                lo_part_next = mix_part;
                state_next   = ST_MIX_HI;
            end
            ST_MIX_HI:
            begin
                // hold here until the output register can take the pixel
                if (out_free)
                begin
                    out_pixel_next = lo_part_reg | mix_part;
                    line_last_next = (remain_reg == COUNT_W'(1));
                    res_valid_next = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    pos_next       = pos_reg + POS_W'(step_reg);
                    burst_next     = burst_reg + 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fmt_reg       <= FMT_ARGB;
            step_reg      <= STEP_W'(256);
            count_reg     <= COUNT_W'(1);
            pos_reg       <= '0;
            idx_reg       <= '0;
            remain_reg    <= '0;
            active_reg    <= 1'b0;
            burst_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fmt_reg       <= fmt_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            remain_reg    <= remain_next;
            active_reg    <= active_next;
            burst_reg     <= burst_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        lo_part_reg   <= lo_part_next;
        out_pixel_reg <= out_pixel_next;
        line_last_reg <= line_last_next;
    end

    assign res_valid = res_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign line_last = line_last_reg;

endmodule

// ===== rtl/hls_checker.sv =====
// Port-level checks for horizontal_linear_scaler_top, with the bind that attaches them.
// No package dependency; sees the top-level ports only.
module hls_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        src_valid,
    input logic        src_stall,
    input logic        line_start,
    input logic        res_valid,
    input logic        res_stall,
    input logic [31:0] out_pixel,
    input logic        line_last
);

    // a result that is held back keeps its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(out_pixel) && $stable(line_last))
        else $error("result changed while stalled");

    // an accepted line start leaves the block idle, so src_stall stays low
    a_start_quick: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall && line_start |=> !src_stall)
        else $error("line start did not finish in one cycle");

    // results only come out of work on an accepted pixel
    a_res_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(src_stall))
        else $error("result appeared while idle");

    // a presented result carries known contents
    a_res_known: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !$isunknown({out_pixel, line_last}))
        else $error("result has unknown bits");

endmodule

bind horizontal_linear_scaler_top hls_checker u_hls_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .line_start (line_start),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_pixel  (out_pixel),
    .line_last  (line_last)
);
